@@ rtl/sac_pkg.sv @@
`timescale 1ns / 1ps
package sac_pkg;

  // Default sizes of the tag engine.
  localparam int MAX_WAYS_DEF   = 8;
  localparam int MAX_SETS_DEF   = 1024;
  localparam int ADDR_WIDTH_DEF = 32;

  // Fixed widths that follow from the largest allowed parameter values.
  localparam int SET_IDX_W   = 16;
  localparam int TAG_W       = 32;
  localparam int WAY_NUM_W   = 5;
  localparam int VICTIM_W    = 4;
  localparam int QUEUE_DEPTH = 2;

  // Random replacement generator.
  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_MASK = 16'hB400;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_WAY_COUNT    = 3'd0,
    CFG_SET_BITS     = 3'd1,
    CFG_OFFSET_BITS  = 3'd2,
    CFG_WRITE_BACK   = 3'd3,
    CFG_REPLACE_MODE = 3'd4
  } cfg_idx_e;

  // Replacement modes; the last code behaves as random.
  typedef enum logic [1:0] {
    REPL_LFU      = 2'd0,
    REPL_LRU      = 2'd1,
    REPL_RAND     = 2'd2,
    REPL_RAND_ALT = 2'd3
  } repl_e;

  typedef struct packed {
    logic [3:0] way_count;
    logic [3:0] set_bits;
    logic [4:0] offset_bits;
    logic       write_back;
    logic [1:0] replace_mode;
  } cfg_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] way;
    logic       mem_read;
    logic [1:0] mem_writes;
    logic       dirty_evict;
  } rsp_t;

  // Classified request travelling from the front end to the back end.
  typedef struct packed {
    logic                 is_write;
    logic [SET_IDX_W-1:0] set_idx;
    logic [TAG_W-1:0]     tag;
  } item_t;

  // Status of the random victim generator.
  typedef struct packed {
    logic                ready;
    logic [VICTIM_W-1:0] victim;
  } rnd_t;

  // Number of ways in use: zero acts as one, large values clip to the maximum.
  function automatic logic [WAY_NUM_W-1:0] active_ways(input logic [3:0] way_count,
                                                       input logic [WAY_NUM_W-1:0] max_ways);
    logic [WAY_NUM_W-1:0] wc;
    wc = {1'b0, way_count};
    if (wc == '0) begin
      return WAY_NUM_W'(1);
    end else if (wc > max_ways) begin
      return max_ways;
    end
    return wc;
  endfunction

  // One step of the Galois LFSR.
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] r;
    r = v >> 1;
    if (v[0]) begin
      r = r ^ LFSR_MASK;
    end
    return r;
  endfunction

  // Four restoring-remainder steps of a 16-bit value; cnt selects the bit group.
  function automatic logic [15:0] mod_step4(input logic [15:0] rem, input logic [16:0] div,
                                            input logic [1:0] cnt);
    logic [31:0] acc;
    logic [31:0] sub;
    int          k;
    acc = {16'b0, rem};
    for (int j = 0; j < 4; j++) begin
      k   = 15 - 4 * int'(cnt) - j;
      sub = {15'b0, div} << k;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[15:0];
  endfunction

endpackage

@@ rtl/sac_queue.sv @@
`timescale 1ns / 1ps
module sac_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sac_pkg::item_t item_i,
  output logic          full_o,
  input  logic          pop_i,
  output sac_pkg::item_t item_o,
  output logic          valid_o
);

  localparam int PTR_W = (sac_pkg::QUEUE_DEPTH > 1) ? $clog2(sac_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(sac_pkg::QUEUE_DEPTH + 1);

  sac_pkg::item_t slot_q [sac_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(sac_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(sac_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(sac_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload slots carry no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/sac_front.sv @@
`timescale 1ns / 1ps
module sac_front #(
  parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
  parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sac_pkg::cfg_t  cfg_i,
  input  logic           accept_i,
  input  sac_pkg::req_t  req_i,
  input  logic           q_full_i,
  output logic           push_o,
  output sac_pkg::item_t item_o,
  output logic           busy_o
);

  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);
  localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);

  logic           valid_q, valid_d;
  logic           done_q, done_d;
  logic [1:0]     cnt_q, cnt_d;
  sac_pkg::item_t item_q, item_d;
  logic [31:0]    addr;
  logic [15:0]    set_raw;
  logic [15:0]    set_mask;

  assign push_o = valid_q && done_q && !q_full_i;
  assign busy_o = valid_q && !push_o;
  assign item_o = item_q;

  // Address split and set index reduction.
  always_comb begin
    addr     = req_i.address & ADDR_MASK;
    set_mask = 16'((17'd1 << cfg_i.set_bits) - 17'd1);
    set_raw  = 16'(addr >> cfg_i.offset_bits) & set_mask;
    valid_d  = valid_q;
    done_d   = done_q;
    cnt_d    = cnt_q;
    item_d   = item_q;
    if (accept_i) begin
      valid_d          = 1'b1;
      done_d           = SETS_POW2;
      cnt_d            = '0;
      item_d.is_write  = req_i.req_type;
      item_d.tag       = addr >> ({1'b0, cfg_i.offset_bits} + {2'b0, cfg_i.set_bits});
      item_d.set_idx   = SETS_POW2 ? (set_raw & 16'(MAX_SETS - 1)) : set_raw;
    end else if (push_o) begin
      valid_d = 1'b0;
    end else if (valid_q && !done_q) begin
      // Remainder by the set count, four bits per cycle.
      item_d.set_idx = sac_pkg::mod_step4(item_q.set_idx, 17'(MAX_SETS), cnt_q);
      cnt_d          = cnt_q + 1'b1;
      done_d         = (cnt_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

@@ rtl/sac_rand.sv @@
`timescale 1ns / 1ps
module sac_rand (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [sac_pkg::WAY_NUM_W-1:0]   ways_i,
  input  logic                            advance_i,
  input  logic                            restart_i,
  output sac_pkg::rnd_t                   rnd_o
);

  logic [15:0] lfsr_q, lfsr_d;
  logic [15:0] rem_q, rem_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;

  assign rnd_o.ready  = !busy_q;
  assign rnd_o.victim = rem_q[sac_pkg::VICTIM_W-1:0];

  // The remainder of the next LFSR value by the way count is kept ready ahead of use.
  always_comb begin
    lfsr_d = advance_i ? sac_pkg::lfsr_step(lfsr_q) : lfsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (advance_i || restart_i) begin
      rem_d  = sac_pkg::lfsr_step(lfsr_d);
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = sac_pkg::mod_step4(rem_q, {12'b0, ways_i}, cnt_q);
      cnt_d  = cnt_q + 1'b1;
      busy_d = (cnt_q != 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= sac_pkg::LFSR_SEED;
      rem_q  <= sac_pkg::lfsr_step(sac_pkg::LFSR_SEED);
      cnt_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      lfsr_q <= lfsr_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule

@@ rtl/sac_back.sv @@
`timescale 1ns / 1ps
module sac_back #(
  parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
  parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sac_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  sac_pkg::item_t q_item_i,
  output logic           q_pop_o,
  input  sac_pkg::rnd_t  rnd_i,
  output logic           rnd_advance_o,
  output logic           clr_active_o,
  output logic           rsp_valid_o,
  output sac_pkg::rsp_t  rsp_o
);

  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W = WAY_W;
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] tag;
    logic                  valid;
    logic                  dirty;
    logic [15:0]           use_cnt;
    logic [RANK_W-1:0]     rank;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  row_t tag_ram [MAX_SETS];

  logic                          clr_active_q, clr_active_d;
  logic [SET_W-1:0]              clr_idx_q, clr_idx_d;
  logic                          ex_valid_q;
  sac_pkg::item_t                ex_item_q;
  logic                          fwd_q, fwd_d;
  row_t                          fwd_row_q;
  row_t                          rd_row_q;
  logic                          rsp_valid_q;
  sac_pkg::rsp_t                 rsp_q, rsp_d;
  logic                          ram_we;
  logic [SET_W-1:0]              ram_waddr;
  row_t                          ram_wdata;
  row_t                          clr_row;
  logic [SET_W-1:0]              pop_set;
  logic [SET_W-1:0]              ex_set;
  logic [ADDR_WIDTH-1:0]         ex_tag;
  logic                          rnd_mode;
  logic [sac_pkg::WAY_NUM_W-1:0] n;
  row_t                          row, new_row;
  logic                          hit;
  logic                          inv_found;
  logic [WAY_W-1:0]              hit_way, inv_way, lfu_way, lru_way, victim, w;
  logic [15:0]                   min_use;
  logic [RANK_W-1:0]             max_rank, w_rank;
  logic                          evict;

  assign clr_active_o  = clr_active_q;
  assign rsp_valid_o   = rsp_valid_q;
  assign rsp_o         = rsp_q;
  assign pop_set       = q_item_i.set_idx[SET_W-1:0];
  assign ex_set        = ex_item_q.set_idx[SET_W-1:0];
  assign ex_tag        = ex_item_q.tag[ADDR_WIDTH-1:0];
  assign rnd_mode      = (cfg_i.replace_mode == sac_pkg::REPL_RAND) ||
                         (cfg_i.replace_mode == sac_pkg::REPL_RAND_ALT);

  // Issue a set read when the random victim (if needed) is settled.
  assign q_pop_o = q_valid_i && !clr_active_q && (!rnd_mode || (rnd_i.ready && !ex_valid_q));
  assign fwd_d   = q_pop_o && ex_valid_q && (ex_set == pop_set);

  // Row written by the clearing pass after reset.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      clr_row[i].tag     = '0;
      clr_row[i].valid   = 1'b0;
      clr_row[i].dirty   = 1'b0;
      clr_row[i].use_cnt = '0;
      clr_row[i].rank    = RANK_W'(i);
    end
  end

  // Lookup, victim choice and line update of the access in execute.
  always_comb begin
    row       = fwd_q ? fwd_row_q : rd_row_q;
    n         = sac_pkg::active_ways(cfg_i.way_count, sac_pkg::WAY_NUM_W'(MAX_WAYS));
    hit       = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (sac_pkg::WAY_NUM_W'(i) < n && row[i].valid && row[i].tag == ex_tag) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (sac_pkg::WAY_NUM_W'(i) < n && !row[i].valid) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
    lfu_way  = '0;
    min_use  = row[0].use_cnt;
    lru_way  = '0;
    max_rank = row[0].rank;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (sac_pkg::WAY_NUM_W'(i) < n && row[i].use_cnt < min_use) begin
        min_use = row[i].use_cnt;
        lfu_way = WAY_W'(i);
      end
      if (sac_pkg::WAY_NUM_W'(i) < n && row[i].rank >= max_rank) begin
        max_rank = row[i].rank;
        lru_way  = WAY_W'(i);
      end
    end
    unique case (cfg_i.replace_mode)
      sac_pkg::REPL_LFU: victim = inv_found ? inv_way : lfu_way;
      sac_pkg::REPL_LRU: victim = lru_way;
      default:           victim = WAY_W'(rnd_i.victim);
    endcase
    w      = hit ? hit_way : victim;
    w_rank = row[w].rank;

    // Move the way to the front of the recency order.
    new_row = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (row[i].rank < w_rank) begin
        new_row[i].rank = row[i].rank + 1'b1;
      end
    end
    new_row[w].rank = '0;

    rsp_d      = '0;
    evict      = 1'b0;
    if (hit) begin
      if (row[w].use_cnt != 16'hFFFF) begin
        new_row[w].use_cnt = row[w].use_cnt + 16'd1;
      end
      if (ex_item_q.is_write) begin
        if (cfg_i.write_back) begin
          new_row[w].dirty = 1'b1;
        end else begin
          rsp_d.mem_writes = 2'd1;
        end
      end
    end else begin
      evict               = row[w].valid && row[w].dirty;
      new_row[w].tag      = ex_tag;
      new_row[w].valid    = 1'b1;
      new_row[w].dirty    = 1'b0;
      new_row[w].use_cnt  = 16'd1;
      rsp_d.mem_writes    = {1'b0, evict} + {1'b0, ex_item_q.is_write};
      rsp_d.mem_read      = !ex_item_q.is_write;
    end
    rsp_d.hit         = hit;
    rsp_d.way         = 3'(w);
    rsp_d.dirty_evict = evict;
  end

  assign rnd_advance_o = ex_valid_q && !hit && rnd_mode;

  // Tag memory write port: clearing pass or execute write-back.
  always_comb begin
    ram_we       = clr_active_q || ex_valid_q;
    ram_waddr    = clr_active_q ? clr_idx_q : ex_set;
    ram_wdata    = clr_active_q ? clr_row : new_row;
    clr_active_d = clr_active_q;
    clr_idx_d    = clr_idx_q;
    if (clr_active_q) begin
      if (clr_idx_q == SET_W'(MAX_SETS - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      tag_ram[ram_waddr] <= ram_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_row_q <= tag_ram[pop_set];
    end
  end

  // Control state of the back end.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
      ex_valid_q   <= 1'b0;
      fwd_q        <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
      ex_valid_q   <= q_pop_o;
      fwd_q        <= fwd_d;
      rsp_valid_q  <= ex_valid_q;
    end
  end

  // Payload registers of the back end.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ex_item_q <= q_item_i;
    end
    if (ex_valid_q) begin
      fwd_row_q <= new_row;
      rsp_q     <= rsp_d;
    end
  end

endmodule

@@ rtl/set_assoc_cache_tag_engine.sv @@
`timescale 1ns / 1ps
// Channel        | Ports                                   | Direction
// -------------- | --------------------------------------- | ---------
// request        | start, busy, req_i                      | in
// result         | rsp_valid_o, rsp_o                      | out
// configuration  | cfg_valid_i, cfg_ready_o, cfg_index_i,  | in
//                | cfg_data_i                              |
//
// A request is taken when start is high and busy is low. Its result is registered in the
// front end, queue, set read, execute and result stages (with set index reduction first
// when MAX_SETS is not a power of two). In LFU and LRU modes the back end takes one
// request per cycle from its two-entry queue; in random mode only while no access is in
// execute, and a miss holds the next one while the LFSR modulo unit settles a new victim.
// After reset the tag memory is cleared one set per cycle over all sets, with busy high.
// The result is shown for one cycle with rsp_valid_o; the receiver cannot stall it.
module set_assoc_cache_tag_engine #(
  parameter int MAX_WAYS   = sac_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS   = sac_pkg::MAX_SETS_DEF,
  parameter int ADDR_WIDTH = sac_pkg::ADDR_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sac_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output sac_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [4:0]    cfg_data_i
);

  sac_pkg::cfg_t  cfg_q, cfg_d;
  logic           cfg_fire;
  logic           start_fire;
  logic           front_busy;
  logic           push;
  sac_pkg::item_t front_item;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  sac_pkg::item_t q_item;
  sac_pkg::rnd_t  rnd;
  logic           rnd_advance;
  logic           clr_active;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign busy        = clr_active || front_busy;
  assign start_fire  = start && !busy;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        sac_pkg::CFG_WAY_COUNT:    cfg_d.way_count    = cfg_data_i[3:0];
        sac_pkg::CFG_SET_BITS:     cfg_d.set_bits     = cfg_data_i[3:0];
        sac_pkg::CFG_OFFSET_BITS:  cfg_d.offset_bits  = cfg_data_i;
        sac_pkg::CFG_WRITE_BACK:   cfg_d.write_back   = cfg_data_i[0];
        sac_pkg::CFG_REPLACE_MODE: cfg_d.replace_mode = cfg_data_i[1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.way_count    <= 4'd2;
      cfg_q.set_bits     <= 4'd4;
      cfg_q.offset_bits  <= 5'd4;
      cfg_q.write_back   <= 1'b0;
      cfg_q.replace_mode <= sac_pkg::REPL_LRU;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: address split and set index.
  sac_front #(
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (start_fire),
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item),
    .busy_o   (front_busy)
  );

  // Queue between front and back.
  sac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  // Random victim generator.
  sac_rand u_rand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ways_i    (sac_pkg::active_ways(cfg_q.way_count, sac_pkg::WAY_NUM_W'(MAX_WAYS))),
    .advance_i (rnd_advance),
    .restart_i (cfg_fire),
    .rnd_o     (rnd)
  );

  // Back end: tag memory lookup and update.
  sac_back #(
    .MAX_WAYS   (MAX_WAYS),
    .MAX_SETS   (MAX_SETS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .rnd_i         (rnd),
    .rnd_advance_o (rnd_advance),
    .clr_active_o  (clr_active),
    .rsp_valid_o   (rsp_valid_o),
    .rsp_o         (rsp_o)
  );

  // A hit never reads memory or evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.hit |-> !rsp_o.mem_read && !rsp_o.dirty_evict)
    else $error("hit reported with memory read or eviction");

  // At most two memory writes per request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.mem_writes != 2'd3)
    else $error("too many memory writes");

  // No result and no queue pop while the tag memory is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active |-> busy && !q_pop && !rsp_valid_o)
    else $error("activity during clearing pass");

  // The random unit only advances on a miss.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_advance |=> rsp_valid_o && !rsp_o.hit)
    else $error("random victim consumed without a miss");

endmodule
